### rtl/assert_macros.svh
// Assertion macros used by the checker file of the dosing timer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### rtl/rdvt_pkg.sv
// Types and constants shared by the dosing timer modules.
package rdvt_pkg;

    localparam int VOL_W       = 10;
    localparam int RATIO_W     = 3;
    localparam int SUM_W       = 5;
    localparam int REG_W       = 8;
    localparam int TIME_W      = 14;
    localparam int PROD_W      = RATIO_W + VOL_W;
    localparam int CFG_IDX_W   = 3;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 8;
    localparam int DIV_STEPS   = TIME_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_B = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_C = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_A   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_B   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_C   = 3'd5;

    localparam logic [REG_W-1:0] OFFSET_A_RST = 8'd8;
    localparam logic [REG_W-1:0] OFFSET_B_RST = 8'd8;
    localparam logic [REG_W-1:0] OFFSET_C_RST = 8'd15;
    localparam logic [REG_W-1:0] RATE_A_RST   = 8'd35;
    localparam logic [REG_W-1:0] RATE_B_RST   = 8'd42;
    localparam logic [REG_W-1:0] RATE_C_RST   = 8'd50;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHARE_GO,
        ST_SHARE_WAIT,
        ST_TIME_WAIT,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        VALVE_A,
        VALVE_B,
        VALVE_C
    } t_valve;

    typedef struct packed {
        logic              start;
        logic [TIME_W-1:0] dividend;
        logic [REG_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [TIME_W-1:0] quotient;
    } t_div_rsp;

endpackage

### rtl/rdvt_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module rdvt_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rdvt_pkg::t_div_req i_req,
    output rdvt_pkg::t_div_rsp o_rsp
);

    localparam logic [rdvt_pkg::DIV_CNT_W-1:0] DIV_LAST =
        rdvt_pkg::DIV_CNT_W'(rdvt_pkg::DIV_STEPS - 1);

    logic                            r_busy;
    logic                            r_done;
    logic [rdvt_pkg::DIV_CNT_W-1:0]  r_cnt;
    logic [rdvt_pkg::REG_W-1:0]      r_rem;
    logic [rdvt_pkg::REG_W-1:0]      r_dvs;
    logic [rdvt_pkg::TIME_W-1:0]     r_quo;
    logic [rdvt_pkg::REG_W:0]        w_trial;
    logic [rdvt_pkg::REG_W+1:0]      w_diff;
    logic                            w_fit;

    assign w_trial = {r_rem, r_quo[rdvt_pkg::TIME_W-1]};
    assign w_diff  = {1'b0, w_trial} - {2'b00, r_dvs};
    assign w_fit   = !w_diff[rdvt_pkg::REG_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= DIV_LAST;
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= w_fit ? w_diff[rdvt_pkg::REG_W-1:0] : w_trial[rdvt_pkg::REG_W-1:0];
            r_quo <= {r_quo[rdvt_pkg::TIME_W-2:0], w_fit};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

### rtl/ratio_dosing_valve_timer.sv
// Top level of the three-valve proportional dosing timer.
// A tick word, or a start word with a zero ratio sum, goes straight to the emit state.
// Other start words first run three share divisions and up to three time divisions on one
// bit-serial divider. The result word is registered from the emit state once the output is free.
// A new word is accepted in idle, once the last result is loaded, while that result still waits.
// Synchronous active-low reset closes all valves, clears the timers and loads default settings.
module ratio_dosing_valve_timer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // tdata: total_volume[9:0], ratio_a[12:10], ratio_b[15:13], ratio_c[18:16], zero fill.
    input  logic [rdvt_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    // tuser: opcode.
    input  logic                                i_s_tuser,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // tdata: valve_a_open[0], valve_b_open[1], valve_c_open[2], pouring[3], zero fill.
    output logic [rdvt_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    output logic                                o_m_tlast,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [rdvt_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rdvt_pkg::REG_W-1:0]          i_cfg_data
);

    localparam int VOL_W   = rdvt_pkg::VOL_W;
    localparam int RATIO_W = rdvt_pkg::RATIO_W;
    localparam int SUM_W   = rdvt_pkg::SUM_W;
    localparam int REG_W   = rdvt_pkg::REG_W;
    localparam int TIME_W  = rdvt_pkg::TIME_W;
    localparam int PROD_W  = rdvt_pkg::PROD_W;

    rdvt_pkg::t_state   r_state, n_state;
    rdvt_pkg::t_valve   r_idx, w_idx_next;
    rdvt_pkg::t_div_req w_req;
    rdvt_pkg::t_div_rsp w_rsp;

    logic [REG_W-1:0]   r_offset_a, r_offset_b, r_offset_c;
    logic [REG_W-1:0]   r_rate_a, r_rate_b, r_rate_c;
    logic [TIME_W-1:0]  r_elapsed, r_close_a, r_close_b, r_close_c, r_longest;
    logic [2:0]         r_valve_bits;
    logic               r_active;
    logic               r_done;
    logic               r_out_valid;
    logic [3:0]         r_out_bits;
    logic               r_out_last;
    logic [VOL_W-1:0]   r_volume;
    logic [RATIO_W-1:0] r_ratio_a, r_ratio_b, r_ratio_c;
    logic [SUM_W-1:0]   r_sum;

    logic               w_acc_in;
    logic               w_op;
    logic [VOL_W-1:0]   w_vol_in;
    logic [RATIO_W-1:0] w_ra_in, w_rb_in, w_rc_in;
    logic [SUM_W-1:0]   w_sum_in;
    logic [RATIO_W-1:0] w_ratio_sel;
    logic [REG_W-1:0]   w_off_sel, w_rate_sel;
    logic [PROD_W-1:0]  w_prod;
    logic [VOL_W-1:0]   w_share, w_excess;
    logic               w_share_fits;
    logic [TIME_W-1:0]  w_time_num;
    logic               w_rec_en;
    logic [TIME_W-1:0]  w_rec_val;
    logic               w_load_out;
    logic [TIME_W-1:0]  w_elapsed_inc;
    logic               w_tick_end;
    logic [2:0]         w_tick_bits;

    rdvt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign o_s_tready  = (r_state == rdvt_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_acc_in    = i_s_tvalid && o_s_tready;
    assign w_op        = i_s_tuser;
    assign w_vol_in    = i_s_tdata[9:0];
    assign w_ra_in     = i_s_tdata[12:10];
    assign w_rb_in     = i_s_tdata[15:13];
    assign w_rc_in     = i_s_tdata[18:16];
    assign w_sum_in    = SUM_W'(w_ra_in) + SUM_W'(w_rb_in) + SUM_W'(w_rc_in);

    always_comb begin
        unique case (r_idx)
            rdvt_pkg::VALVE_A: begin
                w_ratio_sel = r_ratio_a;
                w_off_sel   = r_offset_a;
                w_rate_sel  = r_rate_a;
                w_idx_next  = rdvt_pkg::VALVE_B;
            end
            rdvt_pkg::VALVE_B: begin
                w_ratio_sel = r_ratio_b;
                w_off_sel   = r_offset_b;
                w_rate_sel  = r_rate_b;
                w_idx_next  = rdvt_pkg::VALVE_C;
            end
            default: begin
                w_ratio_sel = r_ratio_c;
                w_off_sel   = r_offset_c;
                w_rate_sel  = r_rate_c;
                w_idx_next  = rdvt_pkg::VALVE_C;
            end
        endcase
    end

    assign w_prod       = PROD_W'(w_ratio_sel) * PROD_W'(r_volume);
    assign w_share      = w_rsp.quotient[VOL_W-1:0];
    assign w_share_fits = w_share > VOL_W'(w_off_sel);
    assign w_excess     = w_share - VOL_W'(w_off_sel);
    assign w_time_num   = TIME_W'({w_excess, 3'b000}) + TIME_W'({w_excess, 1'b0});

    assign w_elapsed_inc = r_elapsed + 1'b1;
    assign w_tick_end    = ({1'b0, w_elapsed_inc} == ({1'b0, r_longest} + 15'd1));

    always_comb begin
        w_tick_bits = r_valve_bits & ~{w_elapsed_inc == r_close_c,
                                       w_elapsed_inc == r_close_b,
                                       w_elapsed_inc == r_close_a};
        if (w_tick_end) begin
            w_tick_bits = 3'b000;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rdvt_pkg::ST_IDLE: begin
                if (w_acc_in) begin
                    if (w_op == rdvt_pkg::OP_START && w_sum_in != '0) begin
                        n_state = rdvt_pkg::ST_SHARE_GO;
                    end else begin
                        n_state = rdvt_pkg::ST_EMIT;
                    end
                end
            end
            rdvt_pkg::ST_SHARE_GO: begin
                n_state = rdvt_pkg::ST_SHARE_WAIT;
            end
            rdvt_pkg::ST_SHARE_WAIT: begin
                if (w_rsp.done) begin
                    if (w_share_fits) begin
                        n_state = rdvt_pkg::ST_TIME_WAIT;
                    end else if (r_idx == rdvt_pkg::VALVE_C) begin
                        n_state = rdvt_pkg::ST_EMIT;
                    end else begin
                        n_state = rdvt_pkg::ST_SHARE_GO;
                    end
                end
            end
            rdvt_pkg::ST_TIME_WAIT: begin
                if (w_rsp.done) begin
                    if (r_idx == rdvt_pkg::VALVE_C) begin
                        n_state = rdvt_pkg::ST_EMIT;
                    end else begin
                        n_state = rdvt_pkg::ST_SHARE_GO;
                    end
                end
            end
            rdvt_pkg::ST_EMIT: begin
                if (!r_out_valid || i_m_tready) begin
                    n_state = rdvt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rdvt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        w_req.start    = 1'b0;
        w_req.dividend = TIME_W'(w_prod);
        w_req.divisor  = REG_W'(r_sum);
        w_rec_en       = 1'b0;
        w_rec_val      = '0;
        w_load_out     = 1'b0;
        unique case (r_state)
            rdvt_pkg::ST_SHARE_GO: begin
                w_req.start = 1'b1;
            end
            rdvt_pkg::ST_SHARE_WAIT: begin
                w_req.dividend = w_time_num;
                w_req.divisor  = (w_rate_sel == '0) ? REG_W'(1) : w_rate_sel;
                w_req.start    = w_rsp.done && w_share_fits;
                w_rec_en       = w_rsp.done && !w_share_fits;
            end
            rdvt_pkg::ST_TIME_WAIT: begin
                w_rec_en  = w_rsp.done;
                w_rec_val = w_rsp.quotient;
            end
            rdvt_pkg::ST_EMIT: begin
                w_load_out = !r_out_valid || i_m_tready;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= rdvt_pkg::ST_IDLE;
            r_idx        <= rdvt_pkg::VALVE_A;
            r_offset_a   <= rdvt_pkg::OFFSET_A_RST;
            r_offset_b   <= rdvt_pkg::OFFSET_B_RST;
            r_offset_c   <= rdvt_pkg::OFFSET_C_RST;
            r_rate_a     <= rdvt_pkg::RATE_A_RST;
            r_rate_b     <= rdvt_pkg::RATE_B_RST;
            r_rate_c     <= rdvt_pkg::RATE_C_RST;
            r_elapsed    <= '0;
            r_close_a    <= '0;
            r_close_b    <= '0;
            r_close_c    <= '0;
            r_longest    <= '0;
            r_valve_bits <= '0;
            r_active     <= 1'b0;
            r_done       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    rdvt_pkg::REG_OFFSET_A: r_offset_a <= i_cfg_data;
                    rdvt_pkg::REG_OFFSET_B: r_offset_b <= i_cfg_data;
                    rdvt_pkg::REG_OFFSET_C: r_offset_c <= i_cfg_data;
                    rdvt_pkg::REG_RATE_A:   r_rate_a   <= i_cfg_data;
                    rdvt_pkg::REG_RATE_B:   r_rate_b   <= i_cfg_data;
                    rdvt_pkg::REG_RATE_C:   r_rate_c   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            if (w_acc_in) begin
                if (w_op == rdvt_pkg::OP_START) begin
                    r_idx        <= rdvt_pkg::VALVE_A;
                    r_elapsed    <= '0;
                    r_close_a    <= '0;
                    r_close_b    <= '0;
                    r_close_c    <= '0;
                    r_longest    <= '0;
                    r_valve_bits <= '0;
                    r_active     <= 1'b1;
                    r_done       <= 1'b0;
                end else if (r_active) begin
                    r_elapsed    <= w_elapsed_inc;
                    r_valve_bits <= w_tick_bits;
                    r_active     <= !w_tick_end;
                    r_done       <= w_tick_end;
                end else begin
                    r_done <= 1'b0;
                end
            end

            if (w_rec_en) begin
                unique case (r_idx)
                    rdvt_pkg::VALVE_A: r_close_a <= w_rec_val;
                    rdvt_pkg::VALVE_B: r_close_b <= w_rec_val;
                    default:           r_close_c <= w_rec_val;
                endcase
                r_valve_bits[r_idx] <= |w_rec_val;
                if (w_rec_val > r_longest) begin
                    r_longest <= w_rec_val;
                end
                r_idx <= w_idx_next;
            end

            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc_in && w_op == rdvt_pkg::OP_START) begin
            r_volume  <= w_vol_in;
            r_ratio_a <= w_ra_in;
            r_ratio_b <= w_rb_in;
            r_ratio_c <= w_rc_in;
            r_sum     <= w_sum_in;
        end
        if (w_load_out) begin
            r_out_bits <= {r_active, r_valve_bits};
            r_out_last <= r_done;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(rdvt_pkg::OUT_TDATA_W - 4){1'b0}}, r_out_bits};
    assign o_m_tlast  = r_out_last;

endmodule

### rtl/rdvt_chk.sv
// Port-level checker for the dosing timer and its bind to the top level.
`include "assert_macros.svh"

module rdvt_chk (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_tvalid,
    input logic                             o_s_tready,
    input logic [rdvt_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    input logic                             i_s_tuser,
    input logic                             o_m_tvalid,
    input logic                             i_m_tready,
    input logic [rdvt_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    input logic                             o_m_tlast,
    input logic                             i_cfg_valid,
    input logic                             o_cfg_ready,
    input logic [rdvt_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input logic [rdvt_pkg::REG_W-1:0]       i_cfg_data
);

    // The word that ends a pour reports the sequence as finished.
    `ASSERT_IMPLY(a_last_not_pouring, i_clk, i_rst_n, o_m_tvalid && o_m_tlast, !o_m_tdata[3])

    // The word that ends a pour reports every valve closed.
    `ASSERT_IMPLY(a_last_all_closed, i_clk, i_rst_n, o_m_tvalid && o_m_tlast, o_m_tdata[2:0] == 3'b000)

    // An open valve is only reported while a pour runs.
    `ASSERT_IMPLY(a_open_needs_pour, i_clk, i_rst_n, o_m_tvalid && (|o_m_tdata[2:0]), o_m_tdata[3])

    // Only one word is worked on at a time.
    `ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready)

    // A stalled result word holds.
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))

endmodule

bind ratio_dosing_valve_timer rdvt_chk u_rdvt_chk (.*);
